@@ rtl/sitda_pkg.sv @@
// Shared constants and types for the signed integer to decimal text converter.
`default_nettype none
package sitda_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int IN_TDATA_W  = ((VALUE_BITS + 7) / 8) * 8;
  localparam int STAGE_STEPS = 8;
  localparam int DD_STAGES   = (VALUE_BITS + STAGE_STEPS - 1) / STAGE_STEPS;
  localparam int DD_BITS     = DD_STAGES * STAGE_STEPS;
  // decimal digits of 2^(VALUE_BITS-1); 1233/4096 approximates log10(2)
  localparam int MAX_DIGITS  = ((VALUE_BITS - 1) * 1233) / 4096 + 1;
  localparam int BCD_W       = MAX_DIGITS * 4;
  localparam int POS_W       = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef struct packed {
    logic               neg;
    logic [DD_BITS-1:0] bin;
    logic [BCD_W-1:0]   bcd;
  } dd_t;

endpackage
`default_nettype wire

@@ rtl/sitda_dd_stage.sv @@
// One pipeline stage of the binary to BCD conversion: eight shift-and-add-3 steps.
`default_nettype none
module sitda_dd_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire sitda_pkg::dd_t in_pl,
  output logic                out_valid,
  input  wire logic           out_ready,
  output sitda_pkg::dd_t      out_pl
);
  import sitda_pkg::*;

  logic valid_r;
  dd_t  pl_r;
  dd_t  pl_nxt;
  logic adv;

  assign adv       = !valid_r || out_ready;
  assign in_ready  = adv;
  assign out_valid = valid_r;
  assign out_pl    = pl_r;

  always_comb begin
    logic [BCD_W-1:0]   bcd;
    logic [DD_BITS-1:0] bin;
    bcd = in_pl.bcd;
    bin = in_pl.bin;
    for (int i = 0; i < STAGE_STEPS; i++) begin
      for (int d = 0; d < MAX_DIGITS; d++) begin
        if (bcd[d*4 +: 4] >= 4'd5) begin
          bcd[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
        end
      end
      bcd = {bcd[BCD_W-2:0], bin[DD_BITS-1]};
      bin = {bin[DD_BITS-2:0], 1'b0};
    end
    pl_nxt.neg = in_pl.neg;
    pl_nxt.bin = bin;
    pl_nxt.bcd = bcd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      pl_r <= pl_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/sitda_emit.sv @@
// Character emitter: walks the BCD digits of one item and drives the output register.
`default_nettype none
module sitda_emit (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire sitda_pkg::dd_t in_pl,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [7:0]          out_tdata,
  output logic                out_tlast
);
  import sitda_pkg::*;

  logic             busy_r;
  logic [BCD_W-1:0] bcd_r;
  logic             neg_r;
  logic [POS_W-1:0] pos_r;
  logic             out_valid_r;
  logic [7:0]       out_char_r;
  logic             out_last_r;

  logic             load;
  logic             out_adv;
  logic             emit;
  logic [POS_W-1:0] top_pos;
  logic [7:0]       char_nxt;
  logic             last_nxt;
  logic [3:0]       digit;

  assign in_ready   = !busy_r;
  assign load       = in_valid && !busy_r;
  assign out_adv    = !out_valid_r || out_tready;
  assign emit       = out_adv && busy_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

  // highest nonzero digit; zero keeps position 0
  always_comb begin
    top_pos = '0;
    for (int d = 0; d < MAX_DIGITS; d++) begin
      if (in_pl.bcd[d*4 +: 4] != 4'd0) begin
        top_pos = POS_W'(d);
      end
    end
  end

  assign digit = bcd_r[pos_r*4 +: 4];

  always_comb begin
    if (neg_r) begin
      char_nxt = CHAR_MINUS;
      last_nxt = 1'b0;
    end else begin
      char_nxt = CHAR_ZERO | {4'd0, digit};
      last_nxt = (pos_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_adv) begin
        out_valid_r <= busy_r;
      end
      if (load) begin
        busy_r <= 1'b1;
      end else if (emit && last_nxt) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bcd_r <= in_pl.bcd;
      neg_r <= in_pl.neg;
      pos_r <= top_pos;
    end else if (emit) begin
      if (neg_r) begin
        neg_r <= 1'b0;
      end else begin
        pos_r <= pos_r - 1'b1;
      end
    end
    if (emit) begin
      out_char_r <= char_nxt;
      out_last_r <= last_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/signed_int_to_decimal_ascii.sv @@
// Top level of the signed integer to decimal ASCII text converter.
// Each input item is a two's complement integer; it comes out as a run of ASCII
// characters, most significant first, with a leading '-' for negative values and
// no leading zeros, tlast set on the final character. The magnitude is formed in
// one register stage and converted to BCD by a pipeline of shift-and-add-3 stages
// (eight bits per stage, four stages at 32 bits); the emitter then loads the
// digits into its own register and puts each character out through its output
// register. The character emitter sends one character per cycle while the output
// is not stalled, and takes a new item only once the previous run's last
// character has left it, while earlier stages may already hold the next items.
`default_nettype none
module signed_int_to_decimal_ascii (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [sitda_pkg::IN_TDATA_W-1:0] in_tdata,   // value
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [7:0]                            out_tdata,  // char_code
  output logic                                  out_tlast   // is_last
);
  import sitda_pkg::*;

  logic                  s0_valid_r;
  dd_t                   s0_r;
  dd_t                   s0_nxt;
  logic                  s0_adv;
  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag;

  logic dd_v   [0:DD_STAGES];
  logic dd_rdy [0:DD_STAGES];
  dd_t  dd_pl  [0:DD_STAGES];

  assign raw = in_tdata[VALUE_BITS-1:0];
  assign mag = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

  always_comb begin
    s0_nxt.neg = raw[VALUE_BITS-1];
    s0_nxt.bin = DD_BITS'(mag);
    s0_nxt.bcd = '0;
  end

  assign s0_adv    = !s0_valid_r || dd_rdy[0];
  assign in_tready = s0_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (s0_adv) begin
      s0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_adv && in_tvalid) begin
      s0_r <= s0_nxt;
    end
  end

  assign dd_v[0]  = s0_valid_r;
  assign dd_pl[0] = s0_r;

  for (genvar s = 0; s < DD_STAGES; s++) begin : g_dd
    sitda_dd_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (dd_v[s]),
      .in_ready  (dd_rdy[s]),
      .in_pl     (dd_pl[s]),
      .out_valid (dd_v[s+1]),
      .out_ready (dd_rdy[s+1]),
      .out_pl    (dd_pl[s+1])
    );
  end

  sitda_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (dd_v[DD_STAGES]),
    .in_ready   (dd_rdy[DD_STAGES]),
    .in_pl      (dd_pl[DD_STAGES]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the signed integer to decimal ASCII converter.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import sitda_pkg::*;

  localparam int VB = VALUE_BITS;

  typedef struct {
    logic [7:0] char_code;
    logic       is_last;
  } char_item_t;

  typedef struct {
    logic [VB-1:0] value;
    string         text;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [7:0]            out_tdata;
  logic                  out_tlast;

  char_item_t expected_chars[$];
  int         errors = 0;
  int         stall_pct = 0;
  bit         hold_off_request = 1'b0;
  int         hold_left = 0;

  int send_idle_pct [4] = '{0, 86, 0, 23};
  int recv_stall_pct[4] = '{0, 0, 86, 23};

  signed_int_to_decimal_ascii u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #5_000_000;
    $display("signed_int_to_decimal_ascii test failed");
    $finish;
  end

  // digits least significant first, then pushed in text order
  function automatic void predict_decimal_text(input logic [VB-1:0] value);
    logic [7:0]      digits[MAX_DIGITS];
    logic [VB-1:0]   mag_bits;
    longint unsigned mag;
    int              n;
    n = 0;
    mag_bits = value[VB-1] ? -value : value;
    mag = mag_bits;
    do begin
      digits[n] = CHAR_ZERO + 8'(mag % 10);
      n++;
      mag = mag / 10;
    end while (mag != 0);
    if (value[VB-1])
      expected_chars.push_back('{CHAR_MINUS, 1'b0});
    for (int k = n - 1; k >= 0; k--)
      expected_chars.push_back('{digits[k], k == 0});
  endfunction

  function automatic void push_text(input string text);
    for (int i = 0; i < text.len(); i++)
      expected_chars.push_back('{text[i], i == text.len() - 1});
  endfunction

  function automatic logic [VB-1:0] rand_value();
    logic [VB-1:0]   v;
    longint unsigned p;
    case ($urandom_range(3))
      0: v = VB'($urandom);
      1: v = VB'($urandom) >> $urandom_range(VB - 1);
      2: begin
        p = 1;
        repeat ($urandom_range(MAX_DIGITS - 1)) p = p * 10;
        v = VB'(p) + VB'($urandom_range(2)) - VB'(1);
        if ($urandom_range(1)) v = -v;
      end
      default: begin
        v = VB'($urandom_range(99));
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_value(input logic [VB-1:0] value, input string text,
                            input int idle_pct);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 60) gap++;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) begin
        in_tdata = IN_TDATA_W'($urandom);
        @(negedge clk);
      end
    end
    in_tvalid = 1'b1;
    in_tdata  = IN_TDATA_W'(value);
    do @(posedge clk); while (!in_tready);
    if (text.len() != 0)
      push_text(text);
    else
      predict_decimal_text(value);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (expected_chars.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  // receiver: random stalls plus a single long hold-off
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        out_tready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    char_item_t exp_item;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected item: char_code %h is_last %b", out_tdata, out_tlast);
        errors++;
      end else begin
        exp_item = expected_chars.pop_front();
        if (out_tdata !== exp_item.char_code) begin
          $error("char_code: expected %h, got %h", exp_item.char_code, out_tdata);
          errors++;
        end
        if (out_tlast !== exp_item.is_last) begin
          $error("is_last: expected %b, got %b", exp_item.is_last, out_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    dir_row_t dir_rows[20];
    dir_rows = '{
      '{VB'(0),            "0"},
      '{VB'(1),            "1"},
      '{-VB'(1),           "-1"},
      '{VB'(9),            "9"},
      '{-VB'(9),           "-9"},
      '{VB'(10),           "10"},
      '{-VB'(10),          "-10"},
      '{VB'(99),           "99"},
      '{VB'(100),          "100"},
      '{32'h7FFFFFFF,      "2147483647"},
      '{32'h80000000,      "-2147483648"},
      '{32'h80000001,      "-2147483647"},
      '{VB'(1000000000),   "1000000000"},
      '{VB'(999999999),    "999999999"},
      '{-VB'(1000000000),  "-1000000000"},
      '{32'hAAAAAAAA,      ""},
      '{32'h55555555,      ""},
      '{VB'(123456789),    ""},
      '{-VB'(987654321),   ""},
      '{32'h00010000,      ""}
    };
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[i])
      send_value(dir_rows[i].value, dir_rows[i].text, 0);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      stall_pct = recv_stall_pct[p];
      for (int i = 0; i < 65; i++) begin
        if (p == 0 && i == 20) hold_off_request = 1'b1;
        if (p == 3 && i == 30) wait_drained();
        send_value(rand_value(), "", send_idle_pct[p]);
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("signed_int_to_decimal_ascii test passed");
    end else begin
      $display("signed_int_to_decimal_ascii test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
rtl/sitda_pkg.sv
rtl/sitda_dd_stage.sv
rtl/sitda_emit.sv
rtl/signed_int_to_decimal_ascii.sv
tb/tb_top.sv
